// ===== rtl/tgl_pkg.sv =====
// text glyph layout: shared types, register indexes and fixed-point helpers
// no dependencies; imported by the top level and the port checker
`timescale 1ns / 1ps

package tgl_pkg;

	// default glyph table depth
	localparam int GLYPH_SLOTS_DEF = 256;

	// field widths
	localparam int POS_W    = 32;
	localparam int DIM_W    = 24;
	localparam int UV_W     = 16;
	localparam int UVD_W    = 17;
	localparam int SC_W     = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CHAR  = 1'b1;

	// character with special handling
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// q8.8 unity scale
	localparam logic [16:0] SCALE_ONE = 17'd256;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X    = 3'd0,
		CFG_ORIGIN_Y    = 3'd1,
		CFG_TEXT_SCALE  = 3'd2,
		CFG_FONT_ASCENT = 3'd3,
		CFG_LINE_PITCH  = 3'd4,
		CFG_FIRST_CODE  = 3'd5,
		CFG_CODE_COUNT  = 3'd6
	} cfg_index_t;

	// one glyph table entry
	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic signed [15:0] box_right;
		logic signed [15:0] box_bottom;
		logic [15:0]        tex_left;
		logic [15:0]        tex_top;
		logic [15:0]        tex_right;
		logic [15:0]        tex_bottom;
		logic signed [15:0] advance;
	} glyph_entry_t;

	// floor(v * s / 256), s is the effective q8.8 scale
	function automatic logic signed [SC_W-1:0] scale_q88(input logic signed [16:0] v,
			input logic [16:0] s);
		logic signed [34:0] p;
		p = v * $signed({1'b0, s});
		return p[33:8];
	endfunction

	// 32-bit add with saturation to the signed range
	function automatic logic signed [POS_W-1:0] sat_add32(input logic signed [POS_W-1:0] a,
			input logic signed [SC_W-1:0] b);
		logic signed [POS_W:0] sum;
		sum = {a[POS_W-1], a} + {{(POS_W+1-SC_W){b[SC_W-1]}}, b};
		if (sum[POS_W] != sum[POS_W-1]) begin
			return sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		return sum[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/text_glyph_layout_top.sv =====
// text glyph layout: glyph table memory, scaling stage and pen cursor
// depends on tgl_pkg
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// in        in   in_valid/in_ready    command, starts_string, code, box_*, tex_*, advance
// out       out  out_valid/out_ready  quad_x/y, quad_width/height, uv_*
// cfg       in   cfg_wr_en            cfg_addr, cfg_wdata
//
// one item per cycle unless out_ready stalls; drawn quads pass s1 and s2 to the out reg
// stages: table read (s1), five 17x18 scale products (s2), pen add and saturate (out reg)
// ascent and line pitch are scaled in two more products, registered from the config
// the pen loop closes in the last stage with one saturating 33-bit add per coordinate
// reset clears control, registers and pen at once; the glyph table is not cleared
// out_ready low holds the output register; bubbles in s1 and s2 still fill behind it

module text_glyph_layout_top
	import tgl_pkg::*;
#(
	parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_DAT_W-1:0]   cfg_wdata,
	// input items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic                   starts_string,
	input  logic [7:0]             code,
	input  logic signed [15:0]     box_left,
	input  logic signed [15:0]     box_top,
	input  logic signed [15:0]     box_right,
	input  logic signed [15:0]     box_bottom,
	input  logic [15:0]            tex_left,
	input  logic [15:0]            tex_top,
	input  logic [15:0]            tex_right,
	input  logic [15:0]            tex_bottom,
	input  logic signed [15:0]     advance,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [POS_W-1:0] quad_x,
	output logic signed [POS_W-1:0] quad_y,
	output logic [DIM_W-1:0]       quad_width,
	output logic [DIM_W-1:0]       quad_height,
	output logic [UV_W-1:0]        uv_left,
	output logic [UV_W-1:0]        uv_top,
	output logic signed [UVD_W-1:0] uv_width,
	output logic signed [UVD_W-1:0] uv_height
);

	localparam int ADDR_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam logic [8:0] SLOTS_9 = 9'(GLYPH_SLOTS);

	// configuration registers
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [15:0]             text_scale_q;
	logic signed [15:0]      font_ascent_q, line_pitch_q;
	logic [7:0]              first_code_q;
	logic [8:0]              code_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			text_scale_q  <= 16'(SCALE_ONE);
			font_ascent_q <= '0;
			line_pitch_q  <= '0;
			first_code_q  <= 8'd32;
			code_count_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_ORIGIN_X:    origin_x_q    <= cfg_wdata;
				CFG_ORIGIN_Y:    origin_y_q    <= cfg_wdata;
				CFG_TEXT_SCALE:  text_scale_q  <= cfg_wdata[15:0];
				CFG_FONT_ASCENT: font_ascent_q <= cfg_wdata[15:0];
				CFG_LINE_PITCH:  line_pitch_q  <= cfg_wdata[15:0];
				CFG_FIRST_CODE:  first_code_q  <= cfg_wdata[7:0];
				CFG_CODE_COUNT:  code_count_q  <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// effective scale, zero meaning unity
	logic [16:0] scale_eff;
	assign scale_eff = (text_scale_q == '0) ? SCALE_ONE : {1'b0, text_scale_q};

	// scaled ascent and line pitch, refreshed every cycle from config
	logic signed [SC_W-1:0] asc_sc_q, pitch_sc_q;

	always_ff @(posedge clk) begin
		asc_sc_q   <= scale_q88({font_ascent_q[15], font_ascent_q}, scale_eff);
		pitch_sc_q <= scale_q88({line_pitch_q[15], line_pitch_q}, scale_eff);
	end

	// pipeline handshake, each stage takes an item when empty or moving
	logic v_s1, v_s2, out_valid_q;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !out_valid_q || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	logic acc, acc_char, acc_write;
	assign acc       = in_valid && in_ready;
	assign acc_char  = acc && (command == CMD_CHAR);
	assign acc_write = acc && (command == CMD_WRITE);

	// slot lookup for a character
	logic [8:0] slot;
	logic [9:0] code_end;
	logic       in_range, is_newline;

	assign slot       = {1'b0, code} - {1'b0, first_code_q};
	assign code_end   = {2'b0, first_code_q} + {1'b0, code_count_q};
	assign in_range   = (code >= first_code_q) && ({2'b0, code} < code_end) && (slot < SLOTS_9);
	assign is_newline = (code == NEWLINE_CODE);

	// glyph table, written on a slot write, read on a character
	glyph_entry_t glyph_mem [GLYPH_SLOTS];
	glyph_entry_t wr_entry, rd_entry_s1;
	logic         wr_en;

	assign wr_en    = acc_write && ({1'b0, code} < SLOTS_9);
	assign wr_entry = '{box_left, box_top, box_right, box_bottom,
		tex_left, tex_top, tex_right, tex_bottom, advance};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			glyph_mem[code[ADDR_W-1:0]] <= wr_entry;
		end
		if (acc_char) begin
			rd_entry_s1 <= glyph_mem[slot[ADDR_W-1:0]];
		end
	end

	// s1 control
	logic starts_s1, newline_s1, glyph_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= acc_char;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_char) begin
			starts_s1  <= starts_string;
			newline_s1 <= is_newline;
			glyph_s1   <= !is_newline && in_range;
		end
	end

	// s2: scale products of the looked-up glyph
	logic                    starts_s2, newline_s2, glyph_s2;
	logic signed [SC_W-1:0]  left_sc_s2, top_sc_s2, wid_sc_s2, hgt_sc_s2, adv_sc_s2;
	logic signed [POS_W-1:0] start_y_s2;
	logic [UV_W-1:0]         uv_left_s2, uv_top_s2;
	logic signed [UVD_W-1:0] uv_w_s2, uv_h_s2;
	logic signed [16:0]      box_w_s1, box_h_s1;

	assign box_w_s1 = {rd_entry_s1.box_right[15], rd_entry_s1.box_right}
		- {rd_entry_s1.box_left[15], rd_entry_s1.box_left};
	assign box_h_s1 = {rd_entry_s1.box_bottom[15], rd_entry_s1.box_bottom}
		- {rd_entry_s1.box_top[15], rd_entry_s1.box_top};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			starts_s2  <= starts_s1;
			newline_s2 <= newline_s1;
			glyph_s2   <= glyph_s1;
			left_sc_s2 <= scale_q88({rd_entry_s1.box_left[15], rd_entry_s1.box_left}, scale_eff);
			top_sc_s2  <= scale_q88({rd_entry_s1.box_top[15], rd_entry_s1.box_top}, scale_eff);
			wid_sc_s2  <= scale_q88(box_w_s1, scale_eff);
			hgt_sc_s2  <= scale_q88(box_h_s1, scale_eff);
			adv_sc_s2  <= scale_q88({rd_entry_s1.advance[15], rd_entry_s1.advance}, scale_eff);
			start_y_s2 <= sat_add32(origin_y_q, asc_sc_q);
			uv_left_s2 <= rd_entry_s1.tex_left;
			uv_top_s2  <= rd_entry_s1.tex_top;
			uv_w_s2    <= {1'b0, rd_entry_s1.tex_right} - {1'b0, rd_entry_s1.tex_left};
			uv_h_s2    <= {1'b0, rd_entry_s1.tex_bottom} - {1'b0, rd_entry_s1.tex_top};
		end
	end

	// pen cursor update and quad placement
	logic signed [POS_W-1:0] pen_x_q, pen_y_q;
	logic signed [POS_W-1:0] base_x, base_y;
	logic                    move3, emit;

	assign move3  = v_s2 && rdy3;
	assign base_x = starts_s2 ? origin_x_q : pen_x_q;
	assign base_y = starts_s2 ? start_y_s2 : pen_y_q;
	assign emit   = glyph_s2 && (wid_sc_s2 > 0) && (hgt_sc_s2 > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (move3) begin
			if (newline_s2) begin
				pen_x_q <= origin_x_q;
				pen_y_q <= sat_add32(base_y, pitch_sc_q);
			end else if (glyph_s2) begin
				pen_x_q <= sat_add32(base_x, adv_sc_s2);
				pen_y_q <= base_y;
			end else begin
				pen_x_q <= base_x;
				pen_y_q <= base_y;
			end
		end
	end

	// output register
	logic signed [POS_W-1:0] quad_x_q, quad_y_q;
	logic [DIM_W-1:0]        quad_w_q, quad_h_q;
	logic [UV_W-1:0]         uv_left_q, uv_top_q;
	logic signed [UVD_W-1:0] uv_w_q, uv_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy3) begin
			out_valid_q <= move3 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (move3 && emit) begin
			quad_x_q  <= sat_add32(base_x, left_sc_s2);
			quad_y_q  <= sat_add32(base_y, top_sc_s2);
			quad_w_q  <= wid_sc_s2[DIM_W-1:0];
			quad_h_q  <= hgt_sc_s2[DIM_W-1:0];
			uv_left_q <= uv_left_s2;
			uv_top_q  <= uv_top_s2;
			uv_w_q    <= uv_w_s2;
			uv_h_q    <= uv_h_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign quad_x      = quad_x_q;
	assign quad_y      = quad_y_q;
	assign quad_width  = quad_w_q;
	assign quad_height = quad_h_q;
	assign uv_left     = uv_left_q;
	assign uv_top      = uv_top_q;
	assign uv_width    = uv_w_q;
	assign uv_height   = uv_h_q;

endmodule

// ===== rtl/tgl_checker.sv =====
// text glyph layout: port-level checker and its bind to the top level
// depends on tgl_pkg and text_glyph_layout_top
`timescale 1ns / 1ps

module tgl_checker
	import tgl_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [POS_W-1:0] quad_x,
	input logic signed [POS_W-1:0] quad_y,
	input logic [DIM_W-1:0]        quad_width,
	input logic [DIM_W-1:0]        quad_height
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result item keeps its position and size
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quad_x) && $stable(quad_y)
			&& $stable(quad_width) && $stable(quad_height))
		else $error("result payload changed while stalled");

	// only glyphs with a positive scaled box are emitted
	a_quad_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quad_width != '0) && (quad_height != '0))
		else $error("empty quad emitted");

	// an empty output register never blocks the input side
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// reset leaves no result pending
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result pending after reset");

endmodule

bind text_glyph_layout_top tgl_checker u_tgl_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for text_glyph_layout_top: directed rows, then random strings
// depends on tgl_pkg and rtl/text_glyph_layout_top.sv; predicts every quad in its own model
`timescale 1ns / 1ps

module testbench;
	import tgl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 100;

	// one input item: command, string flag, code and the glyph slot payload
	typedef struct packed {
		logic         command;
		logic         starts_string;
		logic [7:0]   code;
		glyph_entry_t glyph;
	} layout_item_t;

	// one emitted quad
	typedef struct packed {
		logic signed [POS_W-1:0] quad_x;
		logic signed [POS_W-1:0] quad_y;
		logic [DIM_W-1:0]        quad_width;
		logic [DIM_W-1:0]        quad_height;
		logic [UV_W-1:0]         uv_left;
		logic [UV_W-1:0]         uv_top;
		logic signed [UVD_W-1:0] uv_width;
		logic signed [UVD_W-1:0] uv_height;
	} quad_t;

	typedef enum bit {ROW_SETTING, ROW_ITEM} row_kind_t;

	// one row of the directed sequence
	typedef struct {
		row_kind_t    kind;
		cfg_index_t   reg_index;
		logic [31:0]  value;
		layout_item_t item;
		bit           typed;
		bit           typed_drawn;
		quad_t        typed_quad;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic command;
	logic starts_string;
	logic [7:0] code;
	logic signed [15:0] box_left, box_top, box_right, box_bottom;
	logic [15:0] tex_left, tex_top, tex_right, tex_bottom;
	logic signed [15:0] advance;
	logic out_valid;
	logic out_ready;
	logic signed [POS_W-1:0] quad_x, quad_y;
	logic [DIM_W-1:0] quad_width, quad_height;
	logic [UV_W-1:0] uv_left, uv_top;
	logic signed [UVD_W-1:0] uv_width, uv_height;

	text_glyph_layout_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .starts_string(starts_string), .code(code),
		.box_left(box_left), .box_top(box_top), .box_right(box_right), .box_bottom(box_bottom),
		.tex_left(tex_left), .tex_top(tex_top), .tex_right(tex_right), .tex_bottom(tex_bottom),
		.advance(advance),
		.out_valid(out_valid), .out_ready(out_ready),
		.quad_x(quad_x), .quad_y(quad_y), .quad_width(quad_width), .quad_height(quad_height),
		.uv_left(uv_left), .uv_top(uv_top), .uv_width(uv_width), .uv_height(uv_height)
	);

	always #10 clk = ~clk;

	// layout state mirrored by the testbench
	logic signed [31:0] org_x = '0;
	logic signed [31:0] org_y = '0;
	logic [15:0]        text_scale = 16'd256;
	logic signed [15:0] ascent = '0;
	logic signed [15:0] pitch = '0;
	logic [7:0]         first_code = 8'd32;
	logic [8:0]         code_count = '0;
	longint             pen_x = 0;
	longint             pen_y = 0;
	glyph_entry_t       glyph_store [256];
	bit                 slot_loaded [256];

	quad_t pending_quads[$];
	int    quads_seen = 0;
	int    mismatches = 0;
	int    cycles = 0;
	int    burst_left = 0;

	// q8.8 product, floor toward minus infinity
	function automatic longint apply_scale(input longint v);
		longint s;
		s = (text_scale == 16'd0) ? 256 : longint'(text_scale);
		return (v * s) >>> 8;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic bit is_glyph_code(input logic [7:0] c);
		return c != NEWLINE_CODE && int'(c) >= int'(first_code) &&
			int'(c) < int'(first_code) + int'(code_count);
	endfunction

	// advance the mirrored layout by one item, return the quad it draws
	task automatic lay_out_item(input layout_item_t it, output bit drawn, output quad_t q);
		glyph_entry_t g;
		longint gx, gy, gw, gh;
		int slot;
		drawn = 1'b0;
		q = '0;
		if (it.command == CMD_WRITE) begin
			glyph_store[it.code] = it.glyph;
			slot_loaded[it.code] = 1'b1;
			return;
		end
		if (it.starts_string) begin
			pen_x = longint'(org_x);
			pen_y = clamp32(longint'(org_y) + apply_scale(longint'(ascent)));
		end
		if (it.code == NEWLINE_CODE) begin
			pen_x = longint'(org_x);
			pen_y = clamp32(pen_y + apply_scale(longint'(pitch)));
			return;
		end
		if (!is_glyph_code(it.code)) return;
		slot = int'(it.code) - int'(first_code);
		g = glyph_store[slot];
		gx = clamp32(pen_x + apply_scale(longint'($signed(g.box_left))));
		gy = clamp32(pen_y + apply_scale(longint'($signed(g.box_top))));
		gw = apply_scale(longint'($signed(g.box_right)) - longint'($signed(g.box_left)));
		gh = apply_scale(longint'($signed(g.box_bottom)) - longint'($signed(g.box_top)));
		pen_x = clamp32(pen_x + apply_scale(longint'($signed(g.advance))));
		if (gw > 0 && gh > 0) begin
			drawn = 1'b1;
			q.quad_x = gx[31:0];
			q.quad_y = gy[31:0];
			q.quad_width = gw[23:0];
			q.quad_height = gh[23:0];
			q.uv_left = g.tex_left;
			q.uv_top = g.tex_top;
			q.uv_width = {1'b0, g.tex_right} - {1'b0, g.tex_left};
			q.uv_height = {1'b0, g.tex_bottom} - {1'b0, g.tex_top};
		end
	endtask

	// offer one item in bursts with random gaps, then predict once it is accepted
	task automatic issue(input layout_item_t it, input bit typed, input bit typed_drawn,
			input quad_t typed_quad);
		bit drawn;
		quad_t q;
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		command = it.command;
		starts_string = it.starts_string;
		code = it.code;
		box_left = it.glyph.box_left;
		box_top = it.glyph.box_top;
		box_right = it.glyph.box_right;
		box_bottom = it.glyph.box_bottom;
		tex_left = it.glyph.tex_left;
		tex_top = it.glyph.tex_top;
		tex_right = it.glyph.tex_right;
		tex_bottom = it.glyph.tex_bottom;
		advance = it.glyph.advance;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		lay_out_item(it, drawn, q);
		if (typed) begin
			drawn = typed_drawn;
			q = typed_quad;
		end
		if (drawn) pending_quads.push_back(q);
	endtask

	// stop sending and let every quad and the pipeline drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (pending_quads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_index_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			CFG_ORIGIN_X:    org_x = value;
			CFG_ORIGIN_Y:    org_y = value;
			CFG_TEXT_SCALE:  text_scale = value[15:0];
			CFG_FONT_ASCENT: ascent = value[15:0];
			CFG_LINE_PITCH:  pitch = value[15:0];
			CFG_FIRST_CODE:  first_code = value[7:0];
			CFG_CODE_COUNT:  code_count = value[8:0];
			default: ;
		endcase
	endtask

	// directed rows
	function automatic table_row_t blank_row(input row_kind_t kind);
		table_row_t r;
		r.kind = kind;
		r.reg_index = CFG_ORIGIN_X;
		r.value = '0;
		r.item = '0;
		r.typed = 1'b0;
		r.typed_drawn = 1'b0;
		r.typed_quad = '0;
		return r;
	endfunction

	function automatic table_row_t setting_row(input cfg_index_t idx, input logic [31:0] value);
		table_row_t r;
		r = blank_row(ROW_SETTING);
		r.reg_index = idx;
		r.value = value;
		return r;
	endfunction

	function automatic table_row_t glyph_row(input logic [7:0] slot, input int l, input int t,
			input int rt, input int b, input int ul, input int ut, input int ur, input int ub,
			input int adv);
		table_row_t r;
		r = blank_row(ROW_ITEM);
		r.item.command = CMD_WRITE;
		r.item.starts_string = 1'b1;
		r.item.code = slot;
		r.item.glyph = '{16'(l), 16'(t), 16'(rt), 16'(b), 16'(ul), 16'(ut), 16'(ur), 16'(ub),
			16'(adv)};
		return r;
	endfunction

	function automatic table_row_t char_row(input logic ss, input logic [7:0] c);
		table_row_t r;
		r = blank_row(ROW_ITEM);
		r.item.command = CMD_CHAR;
		r.item.starts_string = ss;
		r.item.code = c;
		return r;
	endfunction

	function automatic table_row_t known_row(input table_row_t r, input bit drawn,
			input quad_t q);
		r.typed = 1'b1;
		r.typed_drawn = drawn;
		r.typed_quad = q;
		return r;
	endfunction

	// random glyph slot contents, mostly well-formed boxes
	function automatic layout_item_t random_glyph_write(input logic [7:0] slot);
		layout_item_t it;
		it.command = CMD_WRITE;
		it.starts_string = 1'($urandom);
		it.code = slot;
		it.glyph.tex_left = 16'($urandom);
		it.glyph.tex_top = 16'($urandom);
		it.glyph.tex_right = 16'($urandom);
		it.glyph.tex_bottom = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			it.glyph.box_left = 16'($urandom_range(0, 4000)) - 16'd2000;
			it.glyph.box_top = 16'($urandom_range(0, 4000)) - 16'd2000;
			it.glyph.box_right = it.glyph.box_left + 16'($urandom_range(0, 3000));
			it.glyph.box_bottom = it.glyph.box_top + 16'($urandom_range(0, 3000));
			it.glyph.advance = 16'($urandom_range(0, 700)) - 16'd100;
		end else begin
			it.glyph.box_left = 16'($urandom);
			it.glyph.box_top = 16'($urandom);
			it.glyph.box_right = 16'($urandom);
			it.glyph.box_bottom = 16'($urandom);
			it.glyph.advance = 16'($urandom);
		end
		return it;
	endfunction

	// never let a character read a slot that holds no glyph yet
	task automatic ensure_loaded(input logic [7:0] c);
		if (is_glyph_code(c) && !slot_loaded[int'(c) - int'(first_code)])
			issue(random_glyph_write(8'(int'(c) - int'(first_code))), 1'b0, 1'b0, '0);
	endtask

	function automatic logic [31:0] pick_origin();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom;
			default: return 32'($urandom_range(0, 200000)) - 32'd100000;
		endcase
	endfunction

	function automatic logic [31:0] pick_metric();
		case ($urandom_range(0, 4))
			0: return 32'h0000_8000;
			1: return 32'h0000_7FFF;
			2: return 32'($urandom_range(0, 65535));
			default: return 32'(16'($urandom_range(0, 1000)) - 16'd200);
		endcase
	endfunction

	task automatic random_settings();
		logic [31:0] scale_val, first_val, count_val;
		case ($urandom_range(0, 6))
			0: scale_val = 32'd0;
			1: scale_val = 32'd1;
			2: scale_val = 32'd65535;
			3: scale_val = 32'd256;
			default: scale_val = 32'($urandom_range(32, 1024));
		endcase
		case ($urandom_range(0, 3))
			0: first_val = 32'd0;
			1: first_val = 32'd255;
			2: first_val = 32'($urandom_range(0, 255));
			default: first_val = 32'($urandom_range(20, 60));
		endcase
		case ($urandom_range(0, 9))
			0: count_val = 32'd0;
			1, 2: count_val = 32'd256;
			3, 4, 5: count_val = 32'($urandom_range(1, 256));
			default: count_val = 32'($urandom_range(20, 100));
		endcase
		wait_idle();
		write_setting(CFG_ORIGIN_X, pick_origin());
		write_setting(CFG_ORIGIN_Y, pick_origin());
		write_setting(CFG_TEXT_SCALE, scale_val);
		write_setting(CFG_FONT_ASCENT, pick_metric());
		write_setting(CFG_LINE_PITCH, pick_metric());
		write_setting(CFG_FIRST_CODE, first_val);
		write_setting(CFG_CODE_COUNT, count_val);
	endtask

	// strings of in-range characters with newlines, slot writes and stray codes
	task automatic run_strings(input int n_items);
		layout_item_t it;
		int sent, str_left, hi, pick;
		sent = 0;
		str_left = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			it = '0;
			if (pick < 15) begin
				it = random_glyph_write(8'($urandom));
				sent++;
			end else if (pick < 22) begin
				it = random_glyph_write(8'($urandom));
				it.command = CMD_CHAR;
				sent++;
			end else begin
				it.command = CMD_CHAR;
				it.starts_string = (str_left == 0);
				if (str_left == 0) str_left = $urandom_range(1, 24);
				str_left--;
				pick = $urandom_range(0, 9);
				hi = int'(first_code) + int'(code_count) - 1;
				if (hi > 255) hi = 255;
				if (pick < 8 && code_count != 0 && hi >= int'(first_code))
					it.code = 8'($urandom_range(int'(first_code), hi));
				else if (pick == 8)
					it.code = NEWLINE_CODE;
				else
					it.code = 8'($urandom);
				sent++;
			end
			if (it.command == CMD_CHAR) ensure_loaded(it.code);
			issue(it, 1'b0, 1'b0, '0);
		end
	endtask

	// output checker
	always @(posedge clk) begin
		quad_t want;
		if (arst_n && out_valid && out_ready) begin
			quads_seen++;
			if (pending_quads.size() == 0) begin
				$error("quad at x %0d y %0d with no item waiting for it", quad_x, quad_y);
				mismatches++;
			end else begin
				want = pending_quads.pop_front();
				if (quad_x !== want.quad_x) begin
					$error("quad_x expected %0d got %0d", want.quad_x, quad_x);
					mismatches++;
				end
				if (quad_y !== want.quad_y) begin
					$error("quad_y expected %0d got %0d", want.quad_y, quad_y);
					mismatches++;
				end
				if (quad_width !== want.quad_width) begin
					$error("quad_width expected %0d got %0d", want.quad_width, quad_width);
					mismatches++;
				end
				if (quad_height !== want.quad_height) begin
					$error("quad_height expected %0d got %0d", want.quad_height, quad_height);
					mismatches++;
				end
				if (uv_left !== want.uv_left) begin
					$error("uv_left expected %0d got %0d", want.uv_left, uv_left);
					mismatches++;
				end
				if (uv_top !== want.uv_top) begin
					$error("uv_top expected %0d got %0d", want.uv_top, uv_top);
					mismatches++;
				end
				if (uv_width !== want.uv_width) begin
					$error("uv_width expected %0d got %0d", want.uv_width, uv_width);
					mismatches++;
				end
				if (uv_height !== want.uv_height) begin
					$error("uv_height expected %0d got %0d", want.uv_height, uv_height);
					mismatches++;
				end
			end
		end
	end

	// receiver: rotating ready pattern, plus two long hold-offs to back up the block
	initial begin
		int hold, span, long_holds;
		logic [15:0] pattern;
		hold = 0;
		span = 0;
		long_holds = 0;
		pattern = '1;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && long_holds < 2 && quads_seen >= 100 + 150 * long_holds) begin
				hold = 300;
				long_holds++;
			end
			if (span == 0) begin
				pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				span = $urandom_range(20, 80);
			end
			span--;
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = pattern[0];
				pattern = {pattern[0], pattern[15:1]};
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_glyph_layout_top regression: fail");
			$finish;
		end
	end

	// main sequence
	initial begin
		table_row_t directed_rows[$];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		command = CMD_CHAR;
		starts_string = 1'b0;
		code = '0;
		box_left = '0;
		box_top = '0;
		box_right = '0;
		box_bottom = '0;
		tex_left = '0;
		tex_top = '0;
		tex_right = '0;
		tex_bottom = '0;
		advance = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset the code count is zero, so nothing draws
		directed_rows.push_back(glyph_row(8'd0, 0, 0, 16, 32, 0, 0, 100, 200, 16));
		directed_rows.push_back(known_row(char_row(1'b1, 8'd65), 1'b0, '0));
		directed_rows.push_back(known_row(char_row(1'b0, NEWLINE_CODE), 1'b0, '0));
		// three slots from code 32: plain, widest box, empty box
		directed_rows.push_back(setting_row(CFG_CODE_COUNT, 32'd3));
		directed_rows.push_back(glyph_row(8'd1, -32768, -32768, 32767, 32767, 0, 65535, 65535,
			0, 32767));
		directed_rows.push_back(glyph_row(8'd2, 5, 5, 5, 40, 0, 0, 0, 0, 16));
		directed_rows.push_back(known_row(char_row(1'b1, 8'd32), 1'b1,
			quad_t'{32'sd0, 32'sd0, 24'd16, 24'd32, 16'd0, 16'd0, 17'sd100, 17'sd200}));
		directed_rows.push_back(known_row(char_row(1'b0, 8'd32), 1'b1,
			quad_t'{32'sd16, 32'sd0, 24'd16, 24'd32, 16'd0, 16'd0, 17'sd100, 17'sd200}));
		directed_rows.push_back(char_row(1'b0, 8'd33));
		directed_rows.push_back(known_row(char_row(1'b0, 8'd34), 1'b0, '0));
		directed_rows.push_back(known_row(char_row(1'b0, 8'd31), 1'b0, '0));
		directed_rows.push_back(known_row(char_row(1'b0, 8'd35), 1'b0, '0));
		directed_rows.push_back(char_row(1'b0, 8'd32));
		// extreme origin, scale and metrics drive the cursor into saturation
		directed_rows.push_back(setting_row(CFG_ORIGIN_X, 32'h7FFF_FFF0));
		directed_rows.push_back(setting_row(CFG_ORIGIN_Y, 32'h8000_0000));
		directed_rows.push_back(setting_row(CFG_TEXT_SCALE, 32'h0000_FFFF));
		directed_rows.push_back(setting_row(CFG_FONT_ASCENT, 32'h0000_8000));
		directed_rows.push_back(setting_row(CFG_LINE_PITCH, 32'h0000_7FFF));
		directed_rows.push_back(char_row(1'b1, 8'd33));
		directed_rows.push_back(char_row(1'b0, 8'd33));
		directed_rows.push_back(char_row(1'b0, NEWLINE_CODE));
		directed_rows.push_back(char_row(1'b0, 8'd32));
		// zero scale means unity; the last code maps to slot zero
		directed_rows.push_back(setting_row(CFG_TEXT_SCALE, 32'd0));
		directed_rows.push_back(setting_row(CFG_FIRST_CODE, 32'd255));
		directed_rows.push_back(setting_row(CFG_CODE_COUNT, 32'd256));
		directed_rows.push_back(char_row(1'b1, 8'd255));
		directed_rows.push_back(known_row(char_row(1'b0, 8'd0), 1'b0, '0));
		// smallest scale: negative products round toward minus infinity
		directed_rows.push_back(setting_row(CFG_TEXT_SCALE, 32'd1));
		directed_rows.push_back(setting_row(CFG_FIRST_CODE, 32'd0));
		directed_rows.push_back(setting_row(CFG_ORIGIN_X, 32'd0));
		directed_rows.push_back(setting_row(CFG_ORIGIN_Y, 32'd0));
		directed_rows.push_back(glyph_row(8'd3, -1, -1, 300, 300, 1, 2, 3, 4, -1));
		directed_rows.push_back(char_row(1'b1, 8'd1));
		directed_rows.push_back(char_row(1'b0, 8'd3));
		directed_rows.push_back(char_row(1'b0, 8'd0));
		directed_rows.push_back(char_row(1'b0, 8'd3));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETTING) begin
				wait_idle();
				write_setting(directed_rows[i].reg_index, directed_rows[i].value);
			end else begin
				issue(directed_rows[i].item, directed_rows[i].typed,
					directed_rows[i].typed_drawn, directed_rows[i].typed_quad);
			end
		end

		// random phases, each under its own register setting
		repeat (RANDOM_PHASES) begin
			random_settings();
			run_strings(PHASE_ITEMS);
		end

		wait_idle();
		if (mismatches == 0)
			$display("text_glyph_layout_top regression: pass");
		else
			$display("text_glyph_layout_top regression: fail");
		$finish;
	end

endmodule
